// File: rtl/gpt_pkg.sv
// Shared types, op codes and constants for the gamepad serial port with turbo.
package gpt_pkg;

   localparam int OP_W     = 2;
   localparam int BYTE_W   = 8;
   localparam int PAD_W    = 10;
   localparam int FRAME_W  = 32;
   localparam int PORTS    = 2;
   localparam int TURBO_N  = 4;

   localparam logic [OP_W-1:0] OP_READ_ONE  = 2'd0;
   localparam logic [OP_W-1:0] OP_READ_TWO  = 2'd1;
   localparam logic [OP_W-1:0] OP_STROBE    = 2'd2;

   localparam logic [BYTE_W-1:0] SER_BASE  = 8'h40;
   localparam logic [BYTE_W-1:0] SER_FILL  = 8'h80;
   localparam logic [BYTE_W-1:0] BIT_A     = 8'h01;
   localparam logic [BYTE_W-1:0] BUTTON_MASK = 8'hFF;

   localparam int FLAG_TURBO_A = 8;
   localparam int FLAG_TURBO_B = 9;

   // one item as seen by the port state logic
   typedef struct packed {
      logic                go;
      logic [OP_W-1:0]     op;
      logic                strobe_level;
      logic [PAD_W-1:0]    pad_one;
      logic [PAD_W-1:0]    pad_two;
      logic [FRAME_W-1:0]  frame;
   } gpt_cmd_type;

   function automatic logic is_read(input logic [OP_W-1:0] op);
      return (op == OP_READ_ONE) || (op == OP_READ_TWO);
   endfunction

   // buttons with turbo substitution on A (bit 0) and B (bit 1)
   function automatic logic [BYTE_W-1:0] load_port(input logic [PAD_W-1:0] raw,
                                                   input logic pa, input logic pb);
      logic [BYTE_W-1:0] v;
      v = raw[BYTE_W-1:0] & BUTTON_MASK;
      if (raw[FLAG_TURBO_A]) v[0] = pa;
      if (raw[FLAG_TURBO_B]) v[1] = pb;
      return v;
   endfunction

endpackage

// File: rtl/gpt_port_state.sv
// Shift latches, strobe edge detect and turbo alternators for both ports.
module gpt_port_state
   import gpt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  gpt_cmd_type       cmd,
   output logic [BYTE_W-1:0] read_data
);

   logic [BYTE_W-1:0]  latch_ff [PORTS];
   logic [BYTE_W-1:0]  latch_in [PORTS];
   logic               strobe_ff, strobe_in;
   logic [TURBO_N-1:0] turbo_ff, turbo_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic               fall;
   logic [BYTE_W-1:0]  sel_latch;

   assign sel_latch = latch_ff[cmd.op[0]];
   assign read_data = SER_BASE | (sel_latch & BIT_A);
   assign fall      = strobe_ff && !cmd.strobe_level;

   always_comb begin
      latch_in[0] = latch_ff[0];
      latch_in[1] = latch_ff[1];
      strobe_in   = strobe_ff;
      turbo_in    = turbo_ff;
      frame_in    = frame_ff;
      if (cmd.go) begin
         case (cmd.op)
            OP_READ_ONE: begin
               latch_in[0] = (latch_ff[0] >> 1) | SER_FILL;
            end
            OP_READ_TWO: begin
               latch_in[1] = (latch_ff[1] >> 1) | SER_FILL;
            end
            OP_STROBE: begin
               strobe_in = cmd.strobe_level;
               if (fall) begin
                  // new frame: all alternators flip before the load uses them
                  if (cmd.frame != frame_ff) turbo_in = ~turbo_ff;
                  frame_in    = cmd.frame;
                  latch_in[0] = load_port(cmd.pad_one, turbo_in[0], turbo_in[1]);
                  latch_in[1] = load_port(cmd.pad_two, turbo_in[2], turbo_in[3]);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff[0] <= '0;
         latch_ff[1] <= '0;
         strobe_ff   <= 1'b0;
         turbo_ff    <= '0;
         frame_ff    <= '0;
      end else begin
         latch_ff[0] <= latch_in[0];
         latch_ff[1] <= latch_in[1];
         strobe_ff   <= strobe_in;
         turbo_ff    <= turbo_in;
         frame_ff    <= frame_in;
      end
   end

`ifndef ASSERT_OFF
   // alternators start together and always toggle together
   a_turbo_lockstep: assert property (@(posedge clock) disable iff (reset)
      (turbo_ff == 4'b0000) || (turbo_ff == 4'b1111))
      else $error("turbo phases diverged");

   a_read_fills: assert property (@(posedge clock) disable iff (reset)
      cmd.go && (cmd.op == OP_READ_ONE) |=> latch_ff[0][BYTE_W-1])
      else $error("port one latch not filled after read");

   a_strobe_track: assert property (@(posedge clock) disable iff (reset)
      cmd.go && (cmd.op == OP_STROBE) |=> strobe_ff == $past(cmd.strobe_level))
      else $error("strobe level not recorded");

   a_frame_hold: assert property (@(posedge clock) disable iff (reset)
      !(cmd.go && (cmd.op == OP_STROBE) && fall) |=> $stable(frame_ff) && $stable(turbo_ff))
      else $error("frame or turbo changed without falling edge");
`endif

endmodule

// File: rtl/gamepad_serial_port_with_turbo_top.sv
// Top level: input register, port state logic and result register.
//
//  channel | ports         | direction | moves
//  req     | req_valid/ready | in      | one bus access item (read port / strobe write)
//  rsp     | rsp_valid/ready | out     | read data of a port read item
//
// An item is registered on acceptance and retired from the input register once it may
// go on; a read then leaves its result in the result register.
// One item per cycle is sustained unless a read stalls; strobe writes produce no result.
// A read waits in the input register only while the result register is full and
// rsp_ready is low; the input side stalls behind it.
// Synchronous active-high reset clears latches, strobe, turbo phases and frame.
module gamepad_serial_port_with_turbo_top
   import gpt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [OP_W-1:0]    req_op,
   input  logic [BYTE_W-1:0]  req_strobe_value,
   input  logic [PAD_W-1:0]   req_pad_one_buttons,
   input  logic [PAD_W-1:0]   req_pad_two_buttons,
   input  logic [FRAME_W-1:0] req_frame_number,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [BYTE_W-1:0]  rsp_read_data
);

   logic               s1_valid_ff, s1_valid_in;
   logic [OP_W-1:0]    s1_op_ff;
   logic               s1_level_ff;
   logic [PAD_W-1:0]   s1_pad_one_ff, s1_pad_two_ff;
   logic [FRAME_W-1:0] s1_frame_ff;
   logic               out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]  out_data_ff;
   logic               out_free;
   logic               s1_go;
   logic               s1_read;
   logic               req_fire;
   logic [BYTE_W-1:0]  read_data;
   gpt_cmd_type        cmd;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign s1_read   = is_read(s1_op_ff);
   assign s1_go     = s1_valid_ff && (out_free || !s1_read);
   assign req_ready = !s1_valid_ff || s1_go;
   assign req_fire  = req_valid && req_ready;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_go);
   assign out_valid_in = (s1_go && s1_read) || (out_valid_ff && !rsp_ready);

   assign cmd.go           = s1_go;
   assign cmd.op           = s1_op_ff;
   assign cmd.strobe_level = s1_level_ff;
   assign cmd.pad_one      = s1_pad_one_ff;
   assign cmd.pad_two      = s1_pad_two_ff;
   assign cmd.frame        = s1_frame_ff;

   gpt_port_state u_state (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .read_data (read_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff      <= req_op;
         s1_level_ff   <= req_strobe_value[0];
         s1_pad_one_ff <= req_pad_one_buttons;
         s1_pad_two_ff <= req_pad_two_buttons;
         s1_frame_ff   <= req_frame_number;
      end
      if (s1_go && s1_read) begin
         out_data_ff <= read_data;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = out_data_ff;

`ifndef ASSERT_OFF
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_go |=> s1_valid_ff && $stable(s1_op_ff))
      else $error("stalled item lost");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_read |-> out_free)
      else $error("result register overrun");

   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_go && !s1_read && !out_valid_ff |=> !out_valid_ff)
      else $error("result from non-read item");
`endif

endmodule
